// ===== rtl/xsf_pkg.sv =====
`timescale 1ns / 1ps

package xsf_pkg;

    localparam int KEY_W = 7;
    localparam int CODE_W = 8;

    typedef enum logic [2:0] {
        ACT_RX_ERROR = 3'd0,
        ACT_RX_BYTE  = 3'd1,
        ACT_POP      = 3'd2,
        ACT_ENABLE   = 3'd3,
        ACT_DISABLE  = 3'd4,
        ACT_RESET    = 3'd5
    } t_action;

    localparam logic [1:0] REG_ERROR_THRESHOLD = 2'd0;
    localparam logic [1:0] REG_FORWARD_REPEATS = 2'd1;
    localparam logic [1:0] REG_NONE_CODE       = 2'd2;

    localparam logic [7:0] THRESHOLD_RESET = 8'd10;
    localparam logic [7:0] NONE_CODE_RESET = 8'h00;

    typedef struct packed {
        logic             en;
        logic [KEY_W-1:0] key;
    } t_map_rd;

    typedef struct packed {
        logic             en;
        logic [KEY_W-1:0] key;
        logic             val;
    } t_map_wr;

    typedef struct packed {
        logic              push;
        logic              pop;
        logic              clr;
        logic [CODE_W-1:0] data;
    } t_fifo_req;

    typedef struct packed {
        logic full;
        logic empty;
        logic avail_next;
    } t_fifo_stat;

endpackage

// ===== rtl/xsf_keymap.sv =====
`timescale 1ns / 1ps

module xsf_keymap (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  xsf_pkg::t_map_rd  i_rd,
    input  xsf_pkg::t_map_wr  i_wr,
    input  logic              i_clr,
    output logic              o_bit
);

    localparam int NKEYS = 1 << xsf_pkg::KEY_W;

    logic                      r_mem [NKEYS];
    logic                      r_rdata;
    logic [xsf_pkg::KEY_W-1:0] r_rd_key;
    logic [NKEYS-1:0]          r_kvalid;
    logic                      r_fwd_v;
    logic [xsf_pkg::KEY_W-1:0] r_fwd_key;
    logic                      r_fwd_val;

    always_ff @(posedge i_clk) begin
        if (i_wr.en) begin
            r_mem[i_wr.key] <= i_wr.val;
        end
        if (i_rd.en) begin
            r_rdata  <= r_mem[i_rd.key];
            r_rd_key <= i_rd.key;
        end
    end

    // last write since the last clear; the memory read may miss a write made on the same edge
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_kvalid <= '0;
            r_fwd_v  <= 1'b0;
        end else if (i_clr) begin
            r_kvalid <= '0;
            r_fwd_v  <= 1'b0;
        end else if (i_wr.en) begin
            r_kvalid[i_wr.key] <= 1'b1;
            r_fwd_v            <= 1'b1;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_wr.en) begin
            r_fwd_key <= i_wr.key;
            r_fwd_val <= i_wr.val;
        end
    end

    assign o_bit = (r_fwd_v && (r_fwd_key == r_rd_key)) ? r_fwd_val
                                                         : (r_kvalid[r_rd_key] & r_rdata);

endmodule

// ===== rtl/xsf_fifo.sv =====
`timescale 1ns / 1ps

module xsf_fifo #(
    parameter int DEPTH = 16
) (
    input  logic                       i_clk,
    input  logic                       i_rst_n,
    input  xsf_pkg::t_fifo_req         i_req,
    output xsf_pkg::t_fifo_stat        o_stat,
    output logic [xsf_pkg::CODE_W-1:0] o_rdata
);

    localparam int PW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int CW = $clog2(DEPTH + 1);

    logic [xsf_pkg::CODE_W-1:0] r_mem [DEPTH];
    logic [xsf_pkg::CODE_W-1:0] r_rdata;
    logic [PW-1:0]              r_head;
    logic [PW-1:0]              r_tail;
    logic [CW-1:0]              r_count;
    logic [PW-1:0]              n_head;
    logic [PW-1:0]              n_tail;
    logic [CW-1:0]              n_count;
    logic                       w_full;
    logic                       w_empty;
    logic                       w_do_push;
    logic                       w_do_pop;

    assign w_full    = (r_count == CW'(DEPTH));
    assign w_empty   = (r_count == '0);
    assign w_do_push = i_req.push && !w_full;
    assign w_do_pop  = i_req.pop && !w_empty;

    always_comb begin
        n_head  = r_head;
        n_tail  = r_tail;
        n_count = r_count;
        if (i_req.clr) begin
            n_head  = '0;
            n_tail  = '0;
            n_count = '0;
        end else if (w_do_push) begin
            n_tail  = (r_tail == PW'(DEPTH - 1)) ? '0 : r_tail + 1'b1;
            n_count = r_count + 1'b1;
        end else if (w_do_pop) begin
            n_head  = (r_head == PW'(DEPTH - 1)) ? '0 : r_head + 1'b1;
            n_count = r_count - 1'b1;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_do_push && !i_req.clr) begin
            r_mem[r_tail] <= i_req.data;
        end
        // read data register doubles as the result code; it holds until the next pop
        if (w_do_pop && !i_req.clr) begin
            r_rdata <= r_mem[r_head];
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_head  <= '0;
            r_tail  <= '0;
            r_count <= '0;
        end else begin
            r_head  <= n_head;
            r_tail  <= n_tail;
            r_count <= n_count;
        end
    end

    assign o_stat.full       = w_full;
    assign o_stat.empty      = w_empty;
    assign o_stat.avail_next = (n_count != '0);
    assign o_rdata           = r_rdata;

endmodule

// ===== rtl/xt_scan_code_repeat_filter_top.sv =====
`timescale 1ns / 1ps
// Channel   Handshake           Payload
// input     i_valid / o_ready   i_action, i_rx_byte, i_kbd_detected
// output    o_valid / i_ready   o_scan_code, o_code_valid, o_soft_reset_req,
//                               o_detected, o_code_available, o_overflow
// config    APB psel/penable    paddr[3:2] selects threshold, repeats, none code
//
// One item per cycle while the output is not stalled. The key map memory is
// read when an item is accepted; when it advances, it updates map, FIFO and
// flags and loads the result register (the FIFO read data register holds the
// popped code). A map write from the item just ahead is forwarded.
// A stalled output holds the result and the stage behind it; a new item is
// still taken while the result waits, as long as that stage is free.
// Synchronous active-low reset clears flags, counters, pointers and map valid bits.

module xt_scan_code_repeat_filter_top #(
    parameter int FIFO_DEPTH = 16
) (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_valid,
    output logic        o_ready,
    input  logic [2:0]  i_action,
    input  logic [7:0]  i_rx_byte,
    input  logic        i_kbd_detected,
    output logic        o_valid,
    input  logic        i_ready,
    output logic [7:0]  o_scan_code,
    output logic        o_code_valid,
    output logic        o_soft_reset_req,
    output logic        o_detected,
    output logic        o_code_available,
    output logic        o_overflow,
    input  logic        psel,
    input  logic        penable,
    input  logic        pwrite,
    input  logic [3:0]  paddr,
    input  logic [31:0] pwdata,
    output logic [31:0] prdata,
    output logic        pready
);

    logic       w_cfg_wr;
    logic [7:0] r_threshold;
    logic       r_fwd_rep;
    logic [7:0] r_none;

    logic       r_s1_v;
    logic [2:0] r_s1_action;
    logic [7:0] r_s1_byte;
    logic       r_s1_kbd;

    logic       r_enabled;
    logic       r_detected;
    logic [7:0] r_err_cnt;
    logic       n_enabled;
    logic       n_detected;
    logic [7:0] n_err_cnt;

    logic       r_out_v;
    logic       r_code_valid;
    logic       r_sreset;
    logic       r_det_out;
    logic       r_avail;
    logic       r_ovf;
    logic       n_code_valid;
    logic       n_sreset;
    logic       n_ovf;

    logic       w_accept;
    logic       w_adv;
    logic       w_key_down;
    logic       w_code_ok;
    logic [7:0] w_cnt_inc;
    logic [7:0] w_code;

    xsf_pkg::t_map_rd    w_map_rd;
    xsf_pkg::t_map_wr    w_map_wr;
    logic                w_map_clr;
    xsf_pkg::t_fifo_req  w_fifo_req;
    xsf_pkg::t_fifo_stat w_fifo_stat;

    assign w_adv    = r_s1_v && (!r_out_v || i_ready);
    assign o_ready  = !r_s1_v || w_adv;
    assign w_accept = i_valid && o_ready;

    assign w_map_rd.en  = w_accept;
    assign w_map_rd.key = i_rx_byte[xsf_pkg::KEY_W-1:0];

    xsf_keymap u_keymap (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_rd    (w_map_rd),
        .i_wr    (w_map_wr),
        .i_clr   (w_map_clr),
        .o_bit   (w_key_down)
    );

    xsf_fifo #(
        .DEPTH (FIFO_DEPTH)
    ) u_fifo (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_req   (w_fifo_req),
        .o_stat  (w_fifo_stat),
        .o_rdata (w_code)
    );

    assign w_cnt_inc = r_err_cnt + 8'd1;

    always_comb begin
        n_enabled    = r_enabled;
        n_detected   = r_detected;
        n_err_cnt    = r_err_cnt;
        n_code_valid = 1'b0;
        n_sreset     = 1'b0;
        n_ovf        = 1'b0;
        w_code_ok    = 1'b0;
        w_map_wr.en  = 1'b0;
        w_map_wr.key = r_s1_byte[xsf_pkg::KEY_W-1:0];
        w_map_wr.val = !r_s1_byte[7];
        w_map_clr    = 1'b0;
        w_fifo_req.push = 1'b0;
        w_fifo_req.pop  = 1'b0;
        w_fifo_req.clr  = 1'b0;
        w_fifo_req.data = r_s1_byte;
        if (w_adv) begin
            case (r_s1_action)
                xsf_pkg::ACT_RX_ERROR: begin
                    if (r_enabled) begin
                        n_detected = r_detected | r_s1_kbd;
                        if (w_cnt_inc > r_threshold) begin
                            n_sreset  = 1'b1;
                            n_err_cnt = '0;
                        end else begin
                            n_err_cnt = w_cnt_inc;
                        end
                    end
                end
                xsf_pkg::ACT_RX_BYTE: begin
                    if (r_enabled) begin
                        n_detected = r_detected | r_s1_kbd;
                        if (r_s1_byte != r_none) begin
                            // release always passes; make passes unless key held and repeats not forwarded
                            w_code_ok = r_s1_byte[7] || r_fwd_rep || !w_key_down;
                            w_map_wr.en     = w_code_ok;
                            w_fifo_req.push = w_code_ok;
                            n_ovf           = w_code_ok && w_fifo_stat.full;
                        end
                    end
                end
                xsf_pkg::ACT_POP: begin
                    if (r_enabled && !w_fifo_stat.empty) begin
                        w_fifo_req.pop = 1'b1;
                        n_code_valid   = 1'b1;
                    end
                end
                xsf_pkg::ACT_ENABLE: begin
                    w_fifo_req.clr = 1'b1;
                    w_map_clr      = 1'b1;
                    n_enabled      = 1'b1;
                    n_detected     = 1'b0;
                end
                xsf_pkg::ACT_DISABLE: begin
                    n_enabled = 1'b0;
                end
                xsf_pkg::ACT_RESET: begin
                    if (r_enabled) begin
                        w_fifo_req.clr = 1'b1;
                        n_sreset       = 1'b1;
                        n_detected     = 1'b0;
                    end
                end
                default: begin
                end
            endcase
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_s1_v       <= 1'b0;
            r_enabled    <= 1'b0;
            r_detected   <= 1'b0;
            r_err_cnt    <= '0;
            r_out_v      <= 1'b0;
            r_code_valid <= 1'b0;
            r_sreset     <= 1'b0;
            r_det_out    <= 1'b0;
            r_avail      <= 1'b0;
            r_ovf        <= 1'b0;
        end else begin
            if (o_ready) begin
                r_s1_v <= i_valid;
            end
            r_enabled  <= n_enabled;
            r_detected <= n_detected;
            r_err_cnt  <= n_err_cnt;
            if (w_adv) begin
                r_out_v      <= 1'b1;
                r_code_valid <= n_code_valid;
                r_sreset     <= n_sreset;
                r_det_out    <= n_detected;
                r_avail      <= w_fifo_stat.avail_next;
                r_ovf        <= n_ovf;
            end else if (i_ready) begin
                r_out_v <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_accept) begin
            r_s1_action <= i_action;
            r_s1_byte   <= i_rx_byte;
            r_s1_kbd    <= i_kbd_detected;
        end
    end

    assign w_cfg_wr = psel && penable && pwrite;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_threshold <= xsf_pkg::THRESHOLD_RESET;
            r_fwd_rep   <= 1'b0;
            r_none      <= xsf_pkg::NONE_CODE_RESET;
        end else if (w_cfg_wr) begin
            case (paddr[3:2])
                xsf_pkg::REG_ERROR_THRESHOLD: r_threshold <= pwdata[7:0];
                xsf_pkg::REG_FORWARD_REPEATS: r_fwd_rep   <= pwdata[0];
                xsf_pkg::REG_NONE_CODE:       r_none      <= pwdata[7:0];
                default: begin
                end
            endcase
        end
    end

    always_comb begin
        case (paddr[3:2])
            xsf_pkg::REG_ERROR_THRESHOLD: prdata = {24'd0, r_threshold};
            xsf_pkg::REG_FORWARD_REPEATS: prdata = {31'd0, r_fwd_rep};
            xsf_pkg::REG_NONE_CODE:       prdata = {24'd0, r_none};
            default:                      prdata = '0;
        endcase
    end

    assign pready           = 1'b1;
    assign o_valid          = r_out_v;
    assign o_scan_code      = r_code_valid ? w_code : 8'd0;
    assign o_code_valid     = r_code_valid;
    assign o_soft_reset_req = r_sreset;
    assign o_detected       = r_det_out;
    assign o_code_available = r_avail;
    assign o_overflow       = r_ovf;

endmodule

// ===== sim/xt_scan_code_repeat_filter_checker.sv =====
`timescale 1ns / 1ps

module xt_scan_code_repeat_filter_checker #(
    parameter int DEPTH = 16
) (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_in_valid,
    input  logic        i_in_ready,
    input  logic [2:0]  i_action,
    input  logic [7:0]  i_rx_byte,
    input  logic        i_kbd_detected,
    input  logic        i_out_valid,
    input  logic        i_out_ready,
    input  logic [7:0]  i_scan_code,
    input  logic        i_code_valid,
    input  logic        i_soft_reset_req,
    input  logic        i_detected,
    input  logic        i_code_available,
    input  logic        i_overflow,
    input  logic        i_psel,
    input  logic        i_penable,
    input  logic        i_pwrite,
    input  logic [3:0]  i_paddr,
    input  logic [31:0] i_pwdata,
    input  logic        i_pready,
    output int          o_mismatches,
    output int          o_pending,
    output int          o_checked,
    output int          o_popped,
    output int          o_overflows,
    output int          o_soft_resets
);

    typedef struct packed {
        logic [7:0] scan_code;
        logic       code_valid;
        logic       soft_reset_req;
        logic       detected;
        logic       code_available;
        logic       overflow;
    } t_filter_out;

    // register copies
    logic [7:0]   err_limit;
    logic         fwd_repeats;
    logic [7:0]   none_val;

    // filter state
    logic         kbd_en;
    logic         seen_kbd;
    logic [7:0]   err_cnt;
    logic [127:0] keys_down;
    logic [7:0]   code_mem [DEPTH];
    int           wr_ptr;
    int           rd_ptr;
    int           fill;

    t_filter_out  outcome_q[$];
    t_filter_out  next_out;

    int mismatch_count = 0;
    int n_checked = 0;
    int n_popped = 0;
    int n_overflow = 0;
    int n_sreset = 0;

    task automatic report_mismatch(input string msg);
        mismatch_count++;
        $display("[%0t] mismatch: %s", $time, msg);
    endtask

    task automatic clear_codes();
        wr_ptr = 0;
        rd_ptr = 0;
        fill = 0;
    endtask

    task automatic step_filter(input logic [2:0] act, input logic [7:0] rxb,
                               input logic kbd, output t_filter_out res);
        logic [6:0] key_idx;
        logic       take;
        res = '0;
        take = 1'b0;
        key_idx = rxb[6:0];
        case (act)
            xsf_pkg::ACT_RX_ERROR, xsf_pkg::ACT_RX_BYTE: begin
                if (kbd_en) begin
                    if (kbd)
                        seen_kbd = 1'b1;
                    if (act == xsf_pkg::ACT_RX_ERROR) begin
                        err_cnt = err_cnt + 8'd1;
                        if (err_cnt > err_limit) begin
                            res.soft_reset_req = 1'b1;
                            err_cnt = '0;
                        end
                    end else if (rxb != none_val) begin
                        // break codes always pass, makes only when the key is up or repeats are forwarded
                        if (rxb[7]) begin
                            keys_down[key_idx] = 1'b0;
                            take = 1'b1;
                        end else if (fwd_repeats || !keys_down[key_idx]) begin
                            keys_down[key_idx] = 1'b1;
                            take = 1'b1;
                        end
                        if (take) begin
                            if (fill == DEPTH) begin
                                res.overflow = 1'b1;
                            end else begin
                                code_mem[wr_ptr] = rxb;
                                wr_ptr = (wr_ptr + 1) % DEPTH;
                                fill++;
                            end
                        end
                    end
                end
            end
            xsf_pkg::ACT_POP: begin
                if (kbd_en && fill != 0) begin
                    res.scan_code = code_mem[rd_ptr];
                    res.code_valid = 1'b1;
                    rd_ptr = (rd_ptr + 1) % DEPTH;
                    fill--;
                end
            end
            xsf_pkg::ACT_ENABLE: begin
                clear_codes();
                kbd_en = 1'b1;
                seen_kbd = 1'b0;
                keys_down = '0;
            end
            xsf_pkg::ACT_DISABLE: begin
                kbd_en = 1'b0;
            end
            xsf_pkg::ACT_RESET: begin
                if (kbd_en) begin
                    clear_codes();
                    res.soft_reset_req = 1'b1;
                    seen_kbd = 1'b0;
                end
            end
            default: ;
        endcase
        res.detected = seen_kbd;
        res.code_available = (fill != 0);
    endtask

    task automatic check_result();
        t_filter_out want;
        if (outcome_q.size() == 0) begin
            report_mismatch($sformatf("result with nothing expected, scan_code %02h",
                                      i_scan_code));
        end else begin
            want = outcome_q.pop_front();
            n_checked++;
            if (want.code_valid)
                n_popped++;
            if (want.overflow)
                n_overflow++;
            if (want.soft_reset_req)
                n_sreset++;
            if (i_scan_code !== want.scan_code)
                report_mismatch($sformatf("scan_code got %02h want %02h",
                                          i_scan_code, want.scan_code));
            if (i_code_valid !== want.code_valid)
                report_mismatch($sformatf("code_valid got %b want %b",
                                          i_code_valid, want.code_valid));
            if (i_soft_reset_req !== want.soft_reset_req)
                report_mismatch($sformatf("soft_reset_req got %b want %b",
                                          i_soft_reset_req, want.soft_reset_req));
            if (i_detected !== want.detected)
                report_mismatch($sformatf("detected got %b want %b",
                                          i_detected, want.detected));
            if (i_code_available !== want.code_available)
                report_mismatch($sformatf("code_available got %b want %b",
                                          i_code_available, want.code_available));
            if (i_overflow !== want.overflow)
                report_mismatch($sformatf("overflow got %b want %b",
                                          i_overflow, want.overflow));
        end
    endtask

    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            err_limit = xsf_pkg::THRESHOLD_RESET;
            fwd_repeats = 1'b0;
            none_val = xsf_pkg::NONE_CODE_RESET;
            kbd_en = 1'b0;
            seen_kbd = 1'b0;
            err_cnt = '0;
            keys_down = '0;
            clear_codes();
            outcome_q.delete();
        end else begin
            if (i_out_valid && i_out_ready)
                check_result();
            if (i_psel && i_penable && i_pwrite && i_pready) begin
                case (i_paddr[3:2])
                    xsf_pkg::REG_ERROR_THRESHOLD: err_limit = i_pwdata[7:0];
                    xsf_pkg::REG_FORWARD_REPEATS: fwd_repeats = i_pwdata[0];
                    xsf_pkg::REG_NONE_CODE:       none_val = i_pwdata[7:0];
                    default: ;
                endcase
            end
            if (i_in_valid && i_in_ready) begin
                step_filter(i_action, i_rx_byte, i_kbd_detected, next_out);
                outcome_q.push_back(next_out);
            end
        end
        o_pending <= outcome_q.size();
        o_mismatches <= mismatch_count;
        o_checked <= n_checked;
        o_popped <= n_popped;
        o_overflows <= n_overflow;
        o_soft_resets <= n_sreset;
    end

endmodule

// ===== sim/xt_scan_code_repeat_filter_top_test.sv =====
`timescale 1ns / 1ps

module xt_scan_code_repeat_filter_top_test;

    localparam int DEPTH = 16;
    localparam int LIMIT = 200000;

    localparam logic [2:0] ACT_SPARE_6 = 3'd6;
    localparam logic [2:0] ACT_SPARE_7 = 3'd7;

    localparam int MODE_MIX    = 0;
    localparam int MODE_FILL   = 1;
    localparam int MODE_ERRORS = 2;

    logic        i_clk = 1'b0;
    logic        i_rst_n = 1'b0;
    logic        i_valid = 1'b0;
    logic        o_ready;
    logic [2:0]  i_action = xsf_pkg::ACT_POP;
    logic [7:0]  i_rx_byte = '0;
    logic        i_kbd_detected = 1'b0;
    logic        o_valid;
    logic        i_ready = 1'b0;
    logic [7:0]  o_scan_code;
    logic        o_code_valid;
    logic        o_soft_reset_req;
    logic        o_detected;
    logic        o_code_available;
    logic        o_overflow;
    logic        psel = 1'b0;
    logic        penable = 1'b0;
    logic        pwrite = 1'b0;
    logic [3:0]  paddr = '0;
    logic [31:0] pwdata = '0;
    logic [31:0] prdata;
    logic        pready;

    int mismatches;
    int pending;
    int checked;
    int popped;
    int overflows;
    int soft_resets;

    int          cycle_count = 0;
    int          items_sent = 0;
    int          src_idle_pct = 27;
    int          sink_idle_pct = 27;
    logic [7:0]  cfg_none = xsf_pkg::NONE_CODE_RESET;
    logic [6:0]  hot_keys [6];

    xt_scan_code_repeat_filter_top #(
        .FIFO_DEPTH (DEPTH)
    ) dut (
        .i_clk            (i_clk),
        .i_rst_n          (i_rst_n),
        .i_valid          (i_valid),
        .o_ready          (o_ready),
        .i_action         (i_action),
        .i_rx_byte        (i_rx_byte),
        .i_kbd_detected   (i_kbd_detected),
        .o_valid          (o_valid),
        .i_ready          (i_ready),
        .o_scan_code      (o_scan_code),
        .o_code_valid     (o_code_valid),
        .o_soft_reset_req (o_soft_reset_req),
        .o_detected       (o_detected),
        .o_code_available (o_code_available),
        .o_overflow       (o_overflow),
        .psel             (psel),
        .penable          (penable),
        .pwrite           (pwrite),
        .paddr            (paddr),
        .pwdata           (pwdata),
        .prdata           (prdata),
        .pready           (pready)
    );

    xt_scan_code_repeat_filter_checker #(
        .DEPTH (DEPTH)
    ) u_checker (
        .i_clk            (i_clk),
        .i_rst_n          (i_rst_n),
        .i_in_valid       (i_valid),
        .i_in_ready       (o_ready),
        .i_action         (i_action),
        .i_rx_byte        (i_rx_byte),
        .i_kbd_detected   (i_kbd_detected),
        .i_out_valid      (o_valid),
        .i_out_ready      (i_ready),
        .i_scan_code      (o_scan_code),
        .i_code_valid     (o_code_valid),
        .i_soft_reset_req (o_soft_reset_req),
        .i_detected       (o_detected),
        .i_code_available (o_code_available),
        .i_overflow       (o_overflow),
        .i_psel           (psel),
        .i_penable        (penable),
        .i_pwrite         (pwrite),
        .i_paddr          (paddr),
        .i_pwdata         (pwdata),
        .i_pready         (pready),
        .o_mismatches     (mismatches),
        .o_pending        (pending),
        .o_checked        (checked),
        .o_popped         (popped),
        .o_overflows      (overflows),
        .o_soft_resets    (soft_resets)
    );

    always #5 i_clk = ~i_clk;

    always @(posedge i_clk) begin
        cycle_count <= cycle_count + 1;
        i_ready <= ($urandom_range(0, 99) >= sink_idle_pct);
    end

    initial begin
        wait (cycle_count == LIMIT);
        $display("timeout after %0d cycles, %0d results outstanding", LIMIT, pending);
        $display("end of test: mismatches");
        $finish;
    end

    task automatic push_item(input logic [2:0] act, input logic [7:0] rxb, input logic kbd);
        while ($urandom_range(0, 99) < src_idle_pct) begin
            i_valid <= 1'b0;
            @(posedge i_clk);
        end
        i_valid <= 1'b1;
        i_action <= act;
        i_rx_byte <= rxb;
        i_kbd_detected <= kbd;
        @(posedge i_clk);
        while (!o_ready)
            @(posedge i_clk);
        items_sent++;
    endtask

    // hold the sender until every result is back, then let the pipeline settle
    task automatic drain_results();
        i_valid <= 1'b0;
        @(posedge i_clk);
        while (pending != 0)
            @(posedge i_clk);
        repeat (4) @(posedge i_clk);
    endtask

    task automatic write_reg(input logic [1:0] idx, input logic [31:0] val);
        @(posedge i_clk);
        psel <= 1'b1;
        penable <= 1'b0;
        pwrite <= 1'b1;
        paddr <= {idx, 2'b00};
        pwdata <= val;
        @(posedge i_clk);
        penable <= 1'b1;
        @(posedge i_clk);
        while (!pready)
            @(posedge i_clk);
        psel <= 1'b0;
        penable <= 1'b0;
        pwrite <= 1'b0;
    endtask

    task automatic configure(input logic [7:0] thr, input logic fwd, input logic [7:0] nc);
        write_reg(xsf_pkg::REG_ERROR_THRESHOLD, {24'd0, thr});
        write_reg(xsf_pkg::REG_FORWARD_REPEATS, {31'd0, fwd});
        write_reg(xsf_pkg::REG_NONE_CODE, {24'd0, nc});
        cfg_none = nc;
    endtask

    function automatic logic [7:0] pick_byte();
        int r;
        r = $urandom_range(0, 99);
        if (r < 6)
            return cfg_none;
        else if (r < 40)
            return {1'b0, hot_keys[$urandom_range(0, 5)]};
        else if (r < 70)
            return {1'b1, hot_keys[$urandom_range(0, 5)]};
        return 8'($urandom_range(0, 255));
    endfunction

    // make code, typematic repeats, then the break code
    task automatic send_keystroke();
        logic [6:0] key_idx;
        int         reps;
        key_idx = $urandom_range(0, 1) ? hot_keys[$urandom_range(0, 5)]
                                       : 7'($urandom_range(0, 127));
        reps = $urandom_range(1, 4);
        repeat (reps)
            push_item(xsf_pkg::ACT_RX_BYTE, {1'b0, key_idx}, $urandom_range(0, 3) == 0);
        push_item(xsf_pkg::ACT_RX_BYTE, {1'b1, key_idx}, $urandom_range(0, 3) == 0);
    endtask

    task automatic send_random_item(input int mode);
        int         r;
        int         c_err, c_byte, c_pop, c_en, c_dis, c_rst;
        logic [7:0] junk;
        logic       kbd;
        r = $urandom_range(0, 99);
        junk = 8'($urandom_range(0, 255));
        kbd = ($urandom_range(0, 3) == 0);
        case (mode)
            MODE_FILL: begin
                c_err = 4;  c_byte = 76; c_pop = 88; c_en = 92; c_dis = 94; c_rst = 97;
            end
            MODE_ERRORS: begin
                c_err = 88; c_byte = 93; c_pop = 96; c_en = 98; c_dis = 99; c_rst = 100;
            end
            default: begin
                c_err = 8;  c_byte = 50; c_pop = 80; c_en = 86; c_dis = 90; c_rst = 95;
            end
        endcase
        if (r < c_err) begin
            push_item(xsf_pkg::ACT_RX_ERROR, junk, kbd);
        end else if (r < c_byte) begin
            if (mode == MODE_FILL && $urandom_range(0, 1))
                send_keystroke();
            else
                push_item(xsf_pkg::ACT_RX_BYTE, pick_byte(), kbd);
        end else if (r < c_pop) begin
            push_item(xsf_pkg::ACT_POP, junk, kbd);
        end else if (r < c_en) begin
            push_item(xsf_pkg::ACT_ENABLE, junk, kbd);
        end else if (r < c_dis) begin
            push_item(xsf_pkg::ACT_DISABLE, junk, kbd);
        end else if (r < c_rst) begin
            push_item(xsf_pkg::ACT_RESET, junk, kbd);
        end else begin
            push_item($urandom_range(0, 1) ? ACT_SPARE_6 : ACT_SPARE_7, junk, kbd);
        end
    endtask

    initial begin
        int ph;
        int mode;
        int phase_end;
        repeat (10) @(posedge i_clk);
        i_rst_n <= 1'b1;

        // directed: block starts disabled with reset register values
        push_item(xsf_pkg::ACT_POP, 8'h00, 1'b0);
        push_item(xsf_pkg::ACT_RX_ERROR, 8'hFF, 1'b1);
        push_item(xsf_pkg::ACT_RX_BYTE, 8'h1E, 1'b1);
        push_item(xsf_pkg::ACT_RESET, 8'h00, 1'b0);
        push_item(ACT_SPARE_6, 8'hA5, 1'b1);
        push_item(ACT_SPARE_7, 8'h5A, 1'b0);
        push_item(xsf_pkg::ACT_ENABLE, 8'h00, 1'b0);
        push_item(xsf_pkg::ACT_RX_BYTE, 8'h00, 1'b1);
        push_item(xsf_pkg::ACT_RX_BYTE, 8'h1E, 1'b0);
        push_item(xsf_pkg::ACT_RX_BYTE, 8'h1E, 1'b0);
        push_item(xsf_pkg::ACT_RX_BYTE, 8'h9E, 1'b0);
        push_item(xsf_pkg::ACT_RX_BYTE, 8'hFF, 1'b0);
        push_item(xsf_pkg::ACT_RX_BYTE, 8'h7F, 1'b0);
        push_item(xsf_pkg::ACT_RX_BYTE, 8'h80, 1'b0);
        push_item(xsf_pkg::ACT_POP, 8'hFF, 1'b1);
        push_item(xsf_pkg::ACT_POP, 8'h00, 1'b0);
        push_item(xsf_pkg::ACT_RX_ERROR, 8'h00, 1'b0);
        push_item(xsf_pkg::ACT_DISABLE, 8'h00, 1'b0);
        push_item(xsf_pkg::ACT_POP, 8'h00, 1'b0);
        push_item(xsf_pkg::ACT_ENABLE, 8'h00, 1'b0);
        push_item(xsf_pkg::ACT_RX_BYTE, 8'h01, 1'b0);
        push_item(xsf_pkg::ACT_POP, 8'h00, 1'b0);
        push_item(xsf_pkg::ACT_POP, 8'h00, 1'b0);
        push_item(xsf_pkg::ACT_RX_BYTE, 8'h02, 1'b1);
        push_item(xsf_pkg::ACT_RESET, 8'h00, 1'b0);
        push_item(xsf_pkg::ACT_POP, 8'h00, 1'b0);

        for (ph = 0; ph < 12; ph++) begin
            drain_results();
            case (ph)
                0: configure(8'd0, 1'b0, 8'h00);
                1: configure(8'd254, 1'b1, 8'hFF);
                // never exceeded: the error counter has to wrap
                2: configure(8'd255, 1'b0, 8'($urandom_range(0, 255)));
                default: configure(($urandom_range(0, 3) == 0) ? 8'($urandom_range(0, 254))
                                                               : 8'($urandom_range(0, 12)),
                                   1'($urandom_range(0, 1)), 8'($urandom_range(0, 255)));
            endcase
            mode = ph % 3;
            src_idle_pct = (ph == 4 || ph == 5) ? 0 : 27;
            sink_idle_pct = src_idle_pct;
            for (int k = 0; k < 6; k++)
                hot_keys[k] = 7'($urandom_range(0, 127));
            phase_end = items_sent + ((ph == 2) ? 340 : 145);
            push_item(xsf_pkg::ACT_ENABLE, 8'($urandom_range(0, 255)),
                      1'($urandom_range(0, 1)));
            while (items_sent < phase_end) begin
                send_random_item(mode);
                if ($urandom_range(0, 99) == 0)
                    drain_results();
            end
        end

        drain_results();
        repeat (8) @(posedge i_clk);
        $display("sent %0d items, checked %0d results", items_sent, checked);
        $display("%0d codes popped, %0d overflows, %0d soft resets",
                 popped, overflows, soft_resets);
        if (mismatches == 0)
            $display("end of test: clean");
        else
            $display("end of test: mismatches");
        $finish;
    end

endmodule
